FILE: design/cbe_pkg.sv
package cbe_pkg;

  // Field widths of the item and result beats.
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int COORDS   = 6;
  localparam int FRAC_W   = 16;

  // Spline order and limits on the knot count.
  localparam int DEGREE        = 3;
  localparam int MIN_KNOTS     = 8;
  localparam int DEF_MAX_KNOTS = 64;
  localparam int VALUE_WIDTH   = 32;
  localparam int SAT_W         = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;

  // Internal arithmetic widths.
  localparam int DIFF_W  = DATA_W + 1;
  localparam int NUM_W   = DIFF_W + FRAC_W;
  localparam int PROD_W  = DATA_W + DIFF_W;
  localparam int SUM_W   = PROD_W - FRAC_W + 1;
  localparam int ALPHA_LIM_LOG = 30;
  localparam int KREG_N  = 2 * DEGREE;
  localparam int CREG_N  = DEGREE + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_KNOT = 2'd0,
    MODE_CTRL = 2'd1,
    MODE_EVAL = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_WAIT,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef logic [COORDS-1:0][DATA_W-1:0] coord_row_t;

  // Saturates a wide sum to the signed range of SAT_W bits.
  function automatic logic [DATA_W-1:0] sat_value(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = (SUM_W'(1) <<< (SAT_W - 1)) - SUM_W'(1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

endpackage

FILE: design/cbe_ram.sv
module cbe_ram #(
  parameter int DEPTH = cbe_pkg::DEF_MAX_KNOTS,
  parameter int WIDTH = cbe_pkg::DATA_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/cbe_div.sv
module cbe_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [cbe_pkg::NUM_W-1:0]  num_i,
  input  logic signed [cbe_pkg::DIFF_W-1:0] den_i,
  output logic                              done_o,
  output logic [cbe_pkg::DATA_W-1:0]        quot_o
);

  localparam int NW = cbe_pkg::NUM_W;
  localparam int DW = cbe_pkg::DIFF_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dmag_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic          zero_q;
  logic          run_q;
  logic          done_q;

  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;
  logic [DW:0]   trial;
  logic          fits;
  logic [NW-1:0] qmag;
  logic [NW-1:0] lim;
  logic [cbe_pkg::DATA_W-1:0] qclamp;

  // Operand magnitudes; the most negative values map to their unsigned magnitude.
  assign nmag = num_i[NW-1] ? (~num_i + NW'(1)) : num_i;
  assign dmag = den_i[DW-1] ? (~den_i + DW'(1)) : den_i;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_q, acc_q[NW-1]};
  assign fits  = trial >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      done_q <= run_q && !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= nmag;
      rem_q  <= '0;
      dmag_q <= dmag;
      neg_q  <= num_i[NW-1] ^ den_i[DW-1];
      zero_q <= (den_i == '0);
    end else if (run_q) begin
      acc_q <= {acc_q[NW-2:0], fits};
      rem_q <= fits ? DW'(trial - {1'b0, dmag_q}) : DW'(trial);
    end
  end

  // Clamp the quotient magnitude and restore the sign.
  assign qmag   = acc_q;
  assign lim    = NW'(1) << cbe_pkg::ALPHA_LIM_LOG;
  assign qclamp = (qmag > lim) ? cbe_pkg::DATA_W'(lim) : cbe_pkg::DATA_W'(qmag);

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = ~qclamp + cbe_pkg::DATA_W'(1);
    end else begin
      quot_o = qclamp;
    end
  end

  assign done_o = done_q;

endmodule

FILE: design/cbe_blend.sv
module cbe_blend (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cbe_pkg::DATA_W-1:0]  left_i,
  input  logic [cbe_pkg::DATA_W-1:0]  right_i,
  input  logic [cbe_pkg::DATA_W-1:0]  alpha_i,
  output logic [cbe_pkg::DATA_W-1:0]  result_o
);

  localparam int DW = cbe_pkg::DIFF_W;
  localparam int PW = cbe_pkg::PROD_W;
  localparam int SW = cbe_pkg::SUM_W;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] left_q;
  logic signed [PW-1:0] shifted;
  logic signed [SW-1:0] sum;

  assign diff = DW'($signed(right_i)) - DW'($signed(left_i));

  // Alpha times the difference, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'($signed(alpha_i)) * PW'(diff);
      left_q <= SW'($signed(left_i));
    end
  end

  // Floor of the registered Q16 product added to the left point, saturated.
  assign shifted  = prod_q >>> cbe_pkg::FRAC_W;
  assign sum      = left_q + SW'(shifted);
  assign result_o = cbe_pkg::sat_value(sum);

endmodule

FILE: design/cubic_bspline_evaluator.sv
// Cubic B-spline evaluator, de Boor scheme, signed Q16.16.
// Items enter on start when busy is low; mode selects a knot write, a control
// point write or an evaluation at time_value_i. Writes take effect at the
// accepting edge and leave busy low, so the next item can follow at once.
// An evaluation raises busy and later gives one result beat on result_valid_o,
// held for one cycle only; the receiver cannot hold it off.
// An evaluation runs the span search (one knot read per cycle from the knot
// memory), loads the four control points and six knots, then works six nodes,
// each a serial divide (one quotient bit per cycle) and six blends on the
// shared multiplier, and ends in an output state. The result beat and the drop
// of busy fall in the same cycle. A time outside the knot range gives its
// status 1 beat at the end of the span search, with no node work.
// The knot_count register is written through cfg_we_i and cfg_data_i; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset sets knot_count to 8 and returns to idle; the knot and control
// point memories keep no reset value and must be written before use.
module cubic_bspline_evaluator #(
  parameter int MAX_KNOTS = cbe_pkg::DEF_MAX_KNOTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [cbe_pkg::MODE_W-1:0]          mode_i,
  input  logic [cbe_pkg::SLOT_W-1:0]          slot_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   time_value_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   pos_x_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   pos_y_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   pos_z_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   rot_x_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   rot_y_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0]   rot_z_in_i,
  input  logic                                cfg_we_i,
  input  logic [cbe_pkg::COUNT_W-1:0]         cfg_data_i,
  output logic                                result_valid_o,
  output logic                                status_o,
  output logic signed [cbe_pkg::DATA_W-1:0]   pos_x_out_o,
  output logic signed [cbe_pkg::DATA_W-1:0]   pos_y_out_o,
  output logic signed [cbe_pkg::DATA_W-1:0]   pos_z_out_o,
  output logic signed [cbe_pkg::DATA_W-1:0]   rot_x_out_o,
  output logic signed [cbe_pkg::DATA_W-1:0]   rot_y_out_o,
  output logic signed [cbe_pkg::DATA_W-1:0]   rot_z_out_o
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int DW = cbe_pkg::DATA_W;
  localparam int IW = cbe_pkg::COUNT_W;
  localparam int CW = cbe_pkg::COORDS * DW;
  localparam int KN = cbe_pkg::KREG_N;
  localparam int CN = cbe_pkg::CREG_N;

  cbe_pkg::state_e state_q, state_d;

  logic [IW-1:0]            knot_count_q;
  logic [IW-1:0]            nk_q;
  logic [IW-1:0]            idx_q;
  logic [IW-1:0]            s_q;
  logic [IW-1:0]            ne_q;
  logic                     hit_q;
  logic                     ne_hit_q;
  logic signed [DW-1:0]     t_q;
  logic signed [DW-1:0]     prev_q;
  logic [2:0]               cnt_q;
  logic [1:0]               r_q;
  logic [1:0]               m_q;
  logic [2:0]               c_q;
  logic                     ph_q;
  logic [DW-1:0]            alpha_q;
  logic [DW-1:0]            kreg_q [KN];
  cbe_pkg::coord_row_t      creg_q [CN];

  logic                     res_valid_q;
  logic                     res_status_q;
  cbe_pkg::coord_row_t      res_q;

  logic                     accept;
  logic                     slot_ok;
  logic [IW-1:0]            nk_eff;
  logic                     knot_we;
  logic                     coord_we;
  logic [IW-1:0]            knot_ridx;
  logic [IW-1:0]            coord_ridx;
  logic [DW-1:0]            k_rdata;
  logic [CW-1:0]            c_rdata;
  cbe_pkg::coord_row_t      c_wrow;

  logic                     scan_cmp;
  logic                     scan_end;
  logic                     in_span;
  logic                     nonempty;
  logic                     hit_now;
  logic [IW-1:0]            s_now;
  logic                     ne_hit_now;
  logic [IW-1:0]            ne_now;
  logic                     found;
  logic [IW-1:0]            s_final;

  logic signed [DW-1:0]     k0;
  logic signed [DW-1:0]     k1;
  logic signed [cbe_pkg::NUM_W-1:0]  div_num;
  logic signed [cbe_pkg::DIFF_W-1:0] div_den;
  logic                     div_start;
  logic                     div_done;
  logic [DW-1:0]            div_quot;
  logic                     blend_en;
  logic [DW-1:0]            blend_left;
  logic [DW-1:0]            blend_right;
  logic [DW-1:0]            blend_res;
  logic                     node_last;
  logic                     eval_last;

  assign accept  = start && !busy;
  assign slot_ok = (32'(slot_i) < MAX_KNOTS);

  // Knot count in effect, clamped to the supported range.
  always_comb begin
    if (knot_count_q < IW'(cbe_pkg::MIN_KNOTS)) begin
      nk_eff = IW'(cbe_pkg::MIN_KNOTS);
    end else if (32'(knot_count_q) > MAX_KNOTS) begin
      nk_eff = IW'(MAX_KNOTS);
    end else begin
      nk_eff = knot_count_q;
    end
  end

  // Write ports of both memories take the item beats directly.
  assign knot_we  = accept && (mode_i == cbe_pkg::MODE_KNOT) && slot_ok;
  assign coord_we = accept && (mode_i == cbe_pkg::MODE_CTRL) && slot_ok;
  assign c_wrow   = {rot_z_in_i, rot_y_in_i, rot_x_in_i, pos_z_in_i, pos_y_in_i, pos_x_in_i};

  cbe_ram #(.DEPTH(MAX_KNOTS), .WIDTH(DW), .AW(AW)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (knot_we),
    .waddr_i (AW'(slot_i)),
    .wdata_i (time_value_i),
    .raddr_i (AW'(knot_ridx)),
    .rdata_o (k_rdata)
  );

  cbe_ram #(.DEPTH(MAX_KNOTS), .WIDTH(CW), .AW(AW)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (AW'(slot_i)),
    .wdata_i (c_wrow),
    .raddr_i (AW'(coord_ridx)),
    .rdata_o (c_rdata)
  );

  // Span search: knot[idx] arrives while knot[idx-1] sits in prev_q.
  assign scan_cmp   = (idx_q != IW'(cbe_pkg::DEGREE));
  assign scan_end   = (idx_q == nk_q - IW'(cbe_pkg::DEGREE + 1));
  assign in_span    = (prev_q <= t_q) && (t_q < $signed(k_rdata));
  assign nonempty   = (prev_q < $signed(k_rdata));
  assign hit_now    = hit_q || (scan_cmp && in_span);
  assign s_now      = hit_q ? s_q : idx_q - IW'(1);
  assign ne_hit_now = ne_hit_q || (scan_cmp && nonempty);
  assign ne_now     = (scan_cmp && nonempty) ? idx_q - IW'(1) : ne_q;

  // A time equal to the end knot falls back to the last non-empty span.
  always_comb begin
    found   = 1'b0;
    s_final = s_now;
    if (hit_now) begin
      found = 1'b1;
    end else if ((t_q == $signed(k_rdata)) && ne_hit_now) begin
      found   = 1'b1;
      s_final = ne_now;
    end
  end

  // Node operands: kreg holds knots s-2 .. s+3, creg control points s-3 .. s.
  assign k0      = $signed(kreg_q[3'(m_q - 2'd1)]);
  assign k1      = $signed(kreg_q[3'(m_q) + 3'd3 - 3'(r_q)]);
  assign div_num = {cbe_pkg::DIFF_W'(t_q) - cbe_pkg::DIFF_W'(k0), cbe_pkg::FRAC_W'(0)};
  assign div_den = cbe_pkg::DIFF_W'(k1) - cbe_pkg::DIFF_W'(k0);

  assign blend_left  = creg_q[m_q - 2'd1][c_q];
  assign blend_right = creg_q[m_q][c_q];

  assign node_last = ph_q && (c_q == 3'(cbe_pkg::COORDS - 1));
  assign eval_last = (r_q == 2'(cbe_pkg::DEGREE)) && (m_q == r_q);

  cbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  cbe_blend u_blend (
    .clk_i    (clk_i),
    .en_i     (blend_en),
    .left_i   (blend_left),
    .right_i  (blend_right),
    .alpha_i  (alpha_q),
    .result_o (blend_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbe_pkg::ST_IDLE: begin
        if (accept && (mode_i == cbe_pkg::MODE_EVAL)) begin
          state_d = cbe_pkg::ST_SCAN;
        end
      end
      cbe_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = found ? cbe_pkg::ST_LOAD : cbe_pkg::ST_IDLE;
        end
      end
      cbe_pkg::ST_LOAD: begin
        if (cnt_q == 3'(KN)) begin
          state_d = cbe_pkg::ST_DIV;
        end
      end
      cbe_pkg::ST_DIV: begin
        state_d = cbe_pkg::ST_WAIT;
      end
      cbe_pkg::ST_WAIT: begin
        if (div_done) begin
          state_d = cbe_pkg::ST_BLEND;
        end
      end
      cbe_pkg::ST_BLEND: begin
        if (node_last) begin
          state_d = eval_last ? cbe_pkg::ST_OUT : cbe_pkg::ST_DIV;
        end
      end
      cbe_pkg::ST_OUT: begin
        state_d = cbe_pkg::ST_IDLE;
      end
      default: begin
        state_d = cbe_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs: read addresses, unit strobes and busy.
  always_comb begin
    knot_ridx  = IW'(cbe_pkg::DEGREE);
    coord_ridx = s_q - IW'(cbe_pkg::DEGREE) + IW'(cnt_q);
    div_start  = 1'b0;
    blend_en   = 1'b0;
    busy       = 1'b1;
    case (state_q)
      cbe_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      cbe_pkg::ST_SCAN: begin
        knot_ridx = idx_q + IW'(1);
      end
      cbe_pkg::ST_LOAD: begin
        knot_ridx = s_q - IW'(cbe_pkg::DEGREE - 1) + IW'(cnt_q);
      end
      cbe_pkg::ST_DIV: begin
        div_start = 1'b1;
      end
      cbe_pkg::ST_BLEND: begin
        blend_en = !ph_q;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cbe_pkg::ST_IDLE;
      knot_count_q <= IW'(cbe_pkg::MIN_KNOTS);
      res_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      ne_hit_q     <= 1'b0;
      ph_q         <= 1'b0;
    end else begin
      state_q     <= state_d;
      // A result beat follows a missed search or the output state.
      res_valid_q <= ((state_q == cbe_pkg::ST_SCAN) && scan_end && !found) ||
                     (state_q == cbe_pkg::ST_OUT);
      if (cfg_we_i) begin
        knot_count_q <= cfg_data_i;
      end
      case (state_q)
        cbe_pkg::ST_IDLE: begin
          hit_q    <= 1'b0;
          ne_hit_q <= 1'b0;
          ph_q     <= 1'b0;
        end
        cbe_pkg::ST_SCAN: begin
          hit_q    <= hit_now;
          ne_hit_q <= ne_hit_now;
        end
        cbe_pkg::ST_BLEND: begin
          ph_q <= !ph_q;
        end
        default: begin
          ph_q <= 1'b0;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cbe_pkg::ST_IDLE: begin
        idx_q <= IW'(cbe_pkg::DEGREE);
        t_q   <= time_value_i;
        nk_q  <= nk_eff;
      end
      cbe_pkg::ST_SCAN: begin
        prev_q <= $signed(k_rdata);
        idx_q  <= idx_q + IW'(1);
        s_q    <= scan_end ? s_final : s_now;
        ne_q   <= ne_now;
        cnt_q  <= '0;
        if (scan_end && !found) begin
          res_status_q <= 1'b1;
          res_q        <= '0;
        end
      end
      cbe_pkg::ST_LOAD: begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q != 3'd0) begin
          kreg_q[cnt_q - 3'd1] <= k_rdata;
          if (cnt_q <= 3'(CN)) begin
            creg_q[2'(cnt_q - 3'd1)] <= c_rdata;
          end
        end
        r_q <= 2'd1;
        m_q <= 2'(cbe_pkg::DEGREE);
        c_q <= '0;
      end
      cbe_pkg::ST_WAIT: begin
        c_q <= '0;
        if (div_done) begin
          alpha_q <= div_quot;
        end
      end
      cbe_pkg::ST_BLEND: begin
        if (ph_q) begin
          creg_q[m_q][c_q] <= blend_res;
          c_q <= c_q + 3'd1;
        end
        if (node_last && !eval_last) begin
          if (m_q == r_q) begin
            r_q <= r_q + 2'd1;
            m_q <= 2'(cbe_pkg::DEGREE);
          end else begin
            m_q <= m_q - 2'd1;
          end
        end
      end
      cbe_pkg::ST_OUT: begin
        res_status_q <= 1'b0;
        res_q        <= creg_q[CN-1];
      end
      default: begin
        c_q <= c_q;
      end
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign pos_x_out_o    = $signed(res_q[0]);
  assign pos_y_out_o    = $signed(res_q[1]);
  assign pos_z_out_o    = $signed(res_q[2]);
  assign rot_x_out_o    = $signed(res_q[3]);
  assign rot_y_out_o    = $signed(res_q[4]);
  assign rot_z_out_o    = $signed(res_q[5]);

`ifndef ASSERT_OFF
  // A result beat only follows a cycle spent on an evaluation.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result beat without a running evaluation");

  // An out-of-range result carries zero coordinates.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> (res_q == '0))
    else $error("out-of-range result with nonzero coordinates");

  // Write items and no-op items never start an evaluation.
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i != cbe_pkg::MODE_EVAL)) |=> !busy)
    else $error("write item raised busy");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == cbe_pkg::ST_WAIT))
    else $error("divider finished outside the wait state");
`endif

endmodule

FILE: tb/cbe_checker.sv
`timescale 1ns / 100ps

// Watches the item, configuration and result channels of the spline evaluator,
// keeps its own copy of the knot and control point tables, predicts each
// evaluation and compares every result beat with the oldest prediction.
module cbe_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  logic [cbe_pkg::MODE_W-1:0]        mode_i,
  input  logic [cbe_pkg::SLOT_W-1:0]        slot_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] time_value_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] pos_x_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] pos_y_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] pos_z_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] rot_x_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] rot_y_in_i,
  input  logic signed [cbe_pkg::DATA_W-1:0] rot_z_in_i,
  input  logic                              cfg_we_i,
  input  logic [cbe_pkg::COUNT_W-1:0]       cfg_data_i,
  input  logic                              result_valid_o,
  input  logic                              status_o,
  input  logic signed [cbe_pkg::DATA_W-1:0] pos_x_out_o,
  input  logic signed [cbe_pkg::DATA_W-1:0] pos_y_out_o,
  input  logic signed [cbe_pkg::DATA_W-1:0] pos_z_out_o,
  input  logic signed [cbe_pkg::DATA_W-1:0] rot_x_out_o,
  input  logic signed [cbe_pkg::DATA_W-1:0] rot_y_out_o,
  input  logic signed [cbe_pkg::DATA_W-1:0] rot_z_out_o,
  output int                                pending_points,
  output int                                error_count
);
  import cbe_pkg::*;

  localparam int TABLE_N = DEF_MAX_KNOTS;

  typedef struct packed {
    logic                            status;
    logic [COORDS-1:0][DATA_W-1:0]   coord;
  } point_t;

  longint              knot_mem [TABLE_N];
  longint              coord_mem [COORDS][TABLE_N];
  logic [COUNT_W-1:0]  knot_count;
  point_t              expected_points [$];

  // Clamps a wide value to the signed 32-bit range.
  function automatic longint clamp_value(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Interpolation weight in Q16.16 for time t between two knots.
  function automatic longint knot_weight(longint t, longint k0, longint k1);
    longint den;
    longint a;
    den = k1 - k0;
    if (den == 0) begin
      return 0;
    end
    a = ((t - k0) * 65536) / den;
    if (a > (64'sd1 <<< 30)) begin
      a = 64'sd1 <<< 30;
    end
    if (a < -(64'sd1 <<< 30)) begin
      a = -(64'sd1 <<< 30);
    end
    return a;
  endfunction

  // De Boor evaluation of the six coordinates at time tv.
  function automatic point_t eval_point(logic signed [DATA_W-1:0] tv);
    longint t;
    longint nodes [COORDS][4];
    longint w;
    int     nk;
    int     span;
    point_t p;
    t = tv;
    nk = (knot_count < MIN_KNOTS) ? MIN_KNOTS :
         (knot_count > TABLE_N) ? TABLE_N : int'(knot_count);
    span = -1;
    for (int j = DEGREE; j <= nk - 5; j++) begin
      if (span < 0 && knot_mem[j] <= t && t < knot_mem[j+1]) begin
        span = j;
      end
    end
    // Time on the last knot falls back to the last non-empty span.
    if (span < 0 && t == knot_mem[nk-4]) begin
      for (int j = nk - 5; j >= DEGREE; j--) begin
        if (span < 0 && knot_mem[j] < knot_mem[j+1]) begin
          span = j;
        end
      end
    end
    p = '0;
    if (span < 0) begin
      p.status = 1'b1;
      return p;
    end
    for (int c = 0; c < COORDS; c++) begin
      for (int m = 0; m < 4; m++) begin
        nodes[c][m] = coord_mem[c][span-3+m];
      end
    end
    for (int r = 1; r <= DEGREE; r++) begin
      for (int m = 3; m >= r; m--) begin
        w = knot_weight(t, knot_mem[span-3+m], knot_mem[span-3+m+4-r]);
        for (int c = 0; c < COORDS; c++) begin
          nodes[c][m] = clamp_value(nodes[c][m-1] +
                                    ((w * (nodes[c][m] - nodes[c][m-1])) >>> 16));
        end
      end
    end
    for (int c = 0; c < COORDS; c++) begin
      p.coord[c] = nodes[c][3][31:0];
    end
    return p;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: MISMATCH on %s: got %h, expected %h", $time, field, got, want);
    error_count++;
  endtask

  // Result beats are compared before new items are predicted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t got;
    point_t want;
    logic [COORDS-1:0][DATA_W-1:0] row;
    if (!rst_ni) begin
      knot_count     <= COUNT_W'(MIN_KNOTS);
      pending_points <= 0;
      error_count    = 0;
    end else begin
      if (result_valid_o) begin
        got.status = status_o;
        got.coord  = {rot_z_out_o, rot_y_out_o, rot_x_out_o,
                      pos_z_out_o, pos_y_out_o, pos_x_out_o};
        if (expected_points.size() == 0) begin
          report_mismatch("result beat with no evaluation pending", 32'd1, 32'd0);
        end else begin
          want = expected_points.pop_front();
          if (got.status !== want.status) begin
            report_mismatch("status", 32'(got.status), 32'(want.status));
          end
          for (int c = 0; c < COORDS; c++) begin
            if (got.coord[c] !== want.coord[c]) begin
              report_mismatch($sformatf("coordinate %0d", c), got.coord[c], want.coord[c]);
            end
          end
        end
      end
      if (cfg_we_i) begin
        knot_count <= cfg_data_i;
      end
      if (start && !busy) begin
        row = {rot_z_in_i, rot_y_in_i, rot_x_in_i, pos_z_in_i, pos_y_in_i, pos_x_in_i};
        case (mode_e'(mode_i))
          MODE_KNOT: knot_mem[slot_i] = longint'(time_value_i);
          MODE_CTRL: begin
            for (int c = 0; c < COORDS; c++) begin
              coord_mem[c][slot_i] = longint'($signed(row[c]));
            end
          end
          MODE_EVAL: expected_points = {expected_points, eval_point(time_value_i)};
          default: ;
        endcase
      end
      pending_points <= expected_points.size();
    end
  end

endmodule

FILE: tb/tb_cubic_bspline_evaluator.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the spline evaluator; checking lives in cbe_checker.
module tb_cubic_bspline_evaluator;
  import cbe_pkg::*;

  localparam int TABLE_N = DEF_MAX_KNOTS;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic [MODE_W-1:0]        mode_i       = '0;
  logic [SLOT_W-1:0]        slot_i       = '0;
  logic signed [DATA_W-1:0] time_value_i = '0;
  logic signed [DATA_W-1:0] pos_x_in_i   = '0;
  logic signed [DATA_W-1:0] pos_y_in_i   = '0;
  logic signed [DATA_W-1:0] pos_z_in_i   = '0;
  logic signed [DATA_W-1:0] rot_x_in_i   = '0;
  logic signed [DATA_W-1:0] rot_y_in_i   = '0;
  logic signed [DATA_W-1:0] rot_z_in_i   = '0;
  logic                     cfg_we_i     = 1'b0;
  logic [COUNT_W-1:0]       cfg_data_i   = '0;
  logic                     result_valid_o;
  logic                     status_o;
  logic signed [DATA_W-1:0] pos_x_out_o, pos_y_out_o, pos_z_out_o;
  logic signed [DATA_W-1:0] rot_x_out_o, rot_y_out_o, rot_z_out_o;
  int                       pending_points;
  int                       error_count;

  longint knot_shadow [TABLE_N];
  int     burst_left;

  cubic_bspline_evaluator dut (.*);

  cbe_checker u_checker (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // Sends one item beat and then applies the burst and gap pacing.
  task automatic send_item(mode_e m, int sl, logic [31:0] tv,
                           logic [COORDS-1:0][DATA_W-1:0] cp);
    start        <= 1'b1;
    mode_i       <= m;
    slot_i       <= SLOT_W'(sl);
    time_value_i <= tv;
    {rot_z_in_i, rot_y_in_i, rot_x_in_i, pos_z_in_i, pos_y_in_i, pos_x_in_i} <= cp;
    do @(posedge clk_i); while (busy);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Lets every pending evaluation drain before the knot count changes.
  task automatic write_knot_count(logic [COUNT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_points != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] coord_value(int style);
    case (style)
      0: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      1: return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // Writes all knots: four equal first knots, then non-decreasing ones, or plain noise.
  task automatic load_knots(int nk, int style);
    longint k;
    k = longint'($signed($urandom_range(0, 1048575))) - 64'sd1073741824;
    for (int i = 0; i < TABLE_N; i++) begin
      if (style == 3) begin
        k = longint'($signed($urandom()));
      end else if (i > 3 && i < nk - 3) begin
        case (style)
          0: k += $urandom_range(1, 262144);
          1: k += $urandom_range(1, 33554431);
          default: k += ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 65536);
        endcase
      end else if (i >= nk - 3) begin
        k += ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 100);
      end
      knot_shadow[i] = k;
      send_item(MODE_KNOT, i, k[31:0], '0);
    end
  endtask

  task automatic load_points(int style);
    logic [COORDS-1:0][DATA_W-1:0] cp;
    for (int i = 0; i < TABLE_N; i++) begin
      for (int c = 0; c < COORDS; c++) begin
        cp[c] = coord_value(style);
      end
      send_item(MODE_CTRL, i, '0, cp);
    end
  endtask

  // Mostly evaluations (inside a span, knots, range edges, noise), writes and no-ops.
  task automatic run_evals(int nk, int count, int cp_style);
    int     pick;
    int     s;
    longint len;
    longint t;
    logic [COORDS-1:0][DATA_W-1:0] cp;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      s = $urandom_range(3, nk - 5);
      if (pick < 60) begin
        len = knot_shadow[s+1] - knot_shadow[s];
        t = (len > 0) ? knot_shadow[s] + ($urandom() % len) : knot_shadow[s];
      end else if (pick < 70) begin
        t = knot_shadow[s];
      end else if (pick < 78) begin
        t = knot_shadow[nk-4];
      end else if (pick < 82) begin
        t = knot_shadow[3] - 1;
      end else if (pick < 86) begin
        t = knot_shadow[nk-4] + 1;
      end else if (pick < 93) begin
        t = longint'($signed($urandom()));
      end else if (pick < 97) begin
        for (int c = 0; c < COORDS; c++) begin
          cp[c] = coord_value(cp_style);
        end
        send_item(MODE_CTRL, $urandom_range(0, TABLE_N - 1), $urandom(), cp);
        continue;
      end else begin
        send_item(MODE_NONE, $urandom_range(0, TABLE_N - 1), $urandom(), {6{$urandom()}});
        continue;
      end
      send_item(MODE_EVAL, $urandom_range(0, TABLE_N - 1), t[31:0], {6{$urandom()}});
    end
  endtask

  task automatic run_phase(logic [COUNT_W-1:0] cfg, int knot_style, int cp_style, int count);
    int nk;
    nk = (cfg < MIN_KNOTS) ? MIN_KNOTS : (cfg > TABLE_N) ? TABLE_N : int'(cfg);
    write_knot_count(cfg);
    load_knots(nk, knot_style);
    load_points(cp_style);
    run_evals(nk, count, cp_style);
  endtask

  initial begin
    burst_left = $urandom_range(1, 40);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default count of eight, both ends of the time range, first and last knot.
    load_knots(MIN_KNOTS, 0);
    load_points(2);
    send_item(MODE_EVAL, 0, 32'h8000_0000, '0);
    send_item(MODE_EVAL, 63, 32'h7fff_ffff, '1);
    send_item(MODE_EVAL, 0, knot_shadow[3][31:0], '0);
    send_item(MODE_EVAL, 0, knot_shadow[MIN_KNOTS-4][31:0], '0);
    send_item(MODE_EVAL, 0, 32'(knot_shadow[3] - 1), '0);
    send_item(MODE_NONE, 63, 32'hffff_ffff, '1);

    run_phase(7'd0, 0, 0, 15);
    run_phase(7'd64, 1, 1, 30);
    run_phase(7'd127, 2, 2, 20);
    run_phase(7'd7, 3, 1, 15);
    run_phase(7'd20, 0, 1, 30);
    run_phase(7'($urandom_range(8, 64)), 1, 0, 40);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_points != 0 || busy) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
